### hdl/lot_sizing_pricing_dp_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lot sizing pricing core
// Concurrent assertion shorthands, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef LOT_SIZING_PRICING_DP_CORE_DEFINES_SVH
`define LOT_SIZING_PRICING_DP_CORE_DEFINES_SVH

// assert a property, disabled while reset is high
`define LSPDP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assert a property at every edge, reset included
`define LSPDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/lspdp_pkg.sv
// ----------------------------------------------------------------------------
// Lot sizing pricing package
// Shared types and constants for the lot sizing pricing core.
// ----------------------------------------------------------------------------
package lspdp_pkg;

   localparam int unsigned W48 = 48;

   localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_HORIZON   = 2'd1;
   localparam logic [1:0] STATUS_ZERO_BETA = 2'd2;

   typedef struct packed {
      logic              done;
      logic signed [47:0] p;
   } mul_res_type;

   typedef struct packed {
      logic              done;
      logic signed [47:0] q;
   } div_res_type;

endpackage

### hdl/lspdp_if.sv
// ----------------------------------------------------------------------------
// Lot sizing pricing channels
// Valid/ready item channels for period requests and results.
// ----------------------------------------------------------------------------
interface lspdp_req_if;
   logic              valid;
   logic              ready;
   logic              first_period;
   logic signed [31:0] alpha;
   logic signed [31:0] beta;
   logic signed [31:0] production_cost;
   logic signed [31:0] storage_cost;
   logic signed [31:0] consumption;
   logic signed [31:0] multiplier;
   logic signed [31:0] setup_cost;

   modport source (output valid, first_period, alpha, beta, production_cost,
                   storage_cost, consumption, multiplier, setup_cost,
                   input ready);
   modport sink (input valid, first_period, alpha, beta, production_cost,
                 storage_cost, consumption, multiplier, setup_cost,
                 output ready);
endinterface

interface lspdp_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] price;
   logic [5:0]        chosen_start;
   logic signed [47:0] best_total;
   logic [1:0]        status;

   modport source (output valid, price, chosen_start, best_total, status,
                   input ready);
   modport sink (input valid, price, chosen_start, best_total, status,
                 output ready);
endinterface

### hdl/lspdp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lspdp_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

### hdl/lspdp_mulq.sv
// ----------------------------------------------------------------------------
// Q.16 multiplier
// Signed 48x48 product, 48x16 partial per cycle, shifted by 16, saturated.
// ----------------------------------------------------------------------------
module lspdp_mulq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [47:0]     a,
   input  logic signed [47:0]     b,
   output lspdp_pkg::mul_res_type res
);

   logic [47:0] ua_ff, ub_ff;
   logic        neg_ff;
   logic [95:0] prod_ff;
   logic [1:0]  k_ff;
   logic        busy_ff, fin_ff, done_ff;
   logic signed [47:0] p_ff;

   logic [15:0] chunk;
   logic [63:0] pp;
   logic [95:0] pp_sh;
   logic [79:0] sh;
   logic [79:0] lim;

   always_comb begin
      case (k_ff)
         2'd0:    chunk = ub_ff[15:0];
         2'd1:    chunk = ub_ff[31:16];
         default: chunk = ub_ff[47:32];
      endcase
      pp = ua_ff * chunk;
      case (k_ff)
         2'd0:    pp_sh = {32'd0, pp};
         2'd1:    pp_sh = {16'd0, pp, 16'd0};
         default: pp_sh = {pp, 32'd0};
      endcase
      sh  = prod_ff[95:16];
      lim = neg_ff ? (80'd1 << 47) : ((80'd1 << 47) - 80'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= 2'd0;
      end else if (start) begin
         ua_ff   <= a[47] ? (48'd0 - a) : a;
         ub_ff   <= b[47] ? (48'd0 - b) : b;
         neg_ff  <= a[47] ^ b[47];
         prod_ff <= 96'd0;
         k_ff    <= 2'd0;
         busy_ff <= 1'b1;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         prod_ff <= prod_ff + pp_sh;
         k_ff    <= k_ff + 2'd1;
         if (k_ff == 2'd2) begin
            busy_ff <= 1'b0;
            fin_ff  <= 1'b1;
         end
      end else if (fin_ff) begin
         fin_ff  <= 1'b0;
         done_ff <= 1'b1;
         if (sh > lim) begin
            p_ff <= neg_ff ? lspdp_pkg::MIN48 : lspdp_pkg::MAX48;
         end else begin
            p_ff <= neg_ff ? $signed(48'd0 - sh[47:0]) : $signed(sh[47:0]);
         end
      end
   end

   assign res.done = done_ff;
   assign res.p    = p_ff;

endmodule

### hdl/lspdp_div.sv
// ----------------------------------------------------------------------------
// Signed divider
// Restoring division, one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module lspdp_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [47:0]     num,
   input  logic signed [33:0]     den,
   output lspdp_pkg::div_res_type res
);

   logic [47:0] un_ff;
   logic [33:0] ud_ff;
   logic [32:0] rem_ff;
   logic [47:0] q_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, fin_ff, done_ff, neg_ff;
   logic signed [47:0] qs_ff;

   logic [33:0] r;
   logic        qbit;
   logic [33:0] rdiff;

   always_comb begin
      r     = {rem_ff, un_ff[47]};
      qbit  = (r >= ud_ff);
      rdiff = r - ud_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else if (start) begin
         un_ff   <= num[47] ? (48'd0 - num) : num;
         ud_ff   <= den[33] ? (34'd0 - den) : den;
         neg_ff  <= num[47] ^ den[33];
         rem_ff  <= 33'd0;
         q_ff    <= 48'd0;
         cnt_ff  <= 6'd47;
         busy_ff <= 1'b1;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         rem_ff <= qbit ? rdiff[32:0] : r[32:0];
         q_ff   <= {q_ff[46:0], qbit};
         un_ff  <= {un_ff[46:0], 1'b0};
         cnt_ff <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_ff <= 1'b0;
            fin_ff  <= 1'b1;
         end
      end else if (fin_ff) begin
         fin_ff  <= 1'b0;
         done_ff <= 1'b1;
         qs_ff   <= neg_ff ? $signed(48'd0 - q_ff) : $signed(q_ff);
      end
   end

   assign res.done = done_ff;
   assign res.q    = qs_ff;

endmodule

### hdl/lot_sizing_pricing_dp_core.sv
// ----------------------------------------------------------------------------
// Lot sizing pricing core
// Wagner-Whitin style recursion with pricing, one planning period per item.
//
//   channel  dir  payload
//   req_if   in   first_period, alpha, beta, production_cost, storage_cost,
//                 consumption, multiplier, setup_cost
//   rsp_if   out  price, chosen_start, best_total, status
//
// An item of period t runs the divider for alpha/(2*beta), overlapped with the
// first product, then each stored candidate in turn on the shared 48x16
// multiplier (two products per candidate); zero beta skips the divider.
// An item past the horizon is answered the next cycle. req_if.ready is high
// only while idle; the result holds until taken. Reset clears the period count and the last storage cost.
// ----------------------------------------------------------------------------
module lot_sizing_pricing_dp_core #(
   parameter int unsigned HORIZON = 64
) (
   input  logic        clock,
   input  logic        reset,
   lspdp_req_if.sink   req_if,
   lspdp_rsp_if.source rsp_if
);

   localparam int unsigned AW = (HORIZON > 1) ? $clog2(HORIZON) : 1;
   localparam int unsigned CW = $clog2(HORIZON + 1);
   localparam int unsigned XW = (AW > 6) ? AW : 6;

   typedef enum logic [3:0] {
      S_IDLE, S_MCS, S_MCW, S_INIT, S_DIV, S_RD, S_LD, S_PR,
      S_MBS, S_MBW, S_MDS, S_MDW, S_C1, S_C2, S_END, S_OUT
   } state_type;

   function automatic logic signed [47:0] sat48_add(input logic signed [47:0] x,
                                                    input logic signed [47:0] y);
      logic signed [48:0] s;
      s = {x[47], x} + {y[47], y};
      if (s[48] != s[47]) begin
         return s[48] ? lspdp_pkg::MIN48 : lspdp_pkg::MAX48;
      end
      return s[47:0];
   endfunction

   function automatic logic signed [47:0] sat48_sub(input logic signed [47:0] x,
                                                    input logic signed [47:0] y);
      logic signed [48:0] s;
      s = {x[47], x} - {y[47], y};
      if (s[48] != s[47]) begin
         return s[48] ? lspdp_pkg::MIN48 : lspdp_pkg::MAX48;
      end
      return s[47:0];
   endfunction

   function automatic logic signed [47:0] ext32(input logic signed [31:0] x);
      return {{16{x[31]}}, x};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
      if (x > 48'sh0000_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end
      if (x < -48'sh0000_8000_0000) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

   state_type state_ff;
   logic [CW-1:0] count_ff;
   logic signed [31:0] ls_ff;
   logic        zero_beta_ff;
   logic signed [31:0] alpha_ff, beta_ff, prod_ff, stor_ff, cons_ff, mult_ff, setup_ff;
   logic [AW-1:0] t_ff, s_ff;
   logic signed [47:0] quot_ff, carry_ff, price_ff, demand_ff, diff_ff, acc_ff;
   logic signed [47:0] acc_rd_ff, bb_rd_ff, cand_ff, best_ff, bprice_ff;
   logic signed [31:0] setup_rd_ff;
   logic [AW-1:0] bidx_ff;
   logic signed [31:0] price_out_ff;
   logic [5:0]  start_out_ff;
   logic signed [47:0] total_out_ff;
   logic [1:0]  status_out_ff;

   logic [CW-1:0] cnt_eff;
   logic        mul_start, div_start;
   logic signed [47:0] mul_a, mul_b;
   lspdp_pkg::mul_res_type mul_res;
   lspdp_pkg::div_res_type div_res;

   logic        cc_we, acc_we, su_we, bb_we;
   logic [AW-1:0] cc_waddr, acc_waddr;
   logic [CW-1:0] bb_waddr;
   logic [47:0] cc_wdata, acc_wdata, bb_wdata, cc_rd, acc_rd, bb_rd;
   logic [31:0] su_rd;
   logic signed [47:0] carry_ld, acc_new, cand2;
   logic [XW-1:0] bidx_x;

   assign cnt_eff  = req_if.first_period ? '0 : count_ff;
   assign carry_ld = (s_ff < t_ff) ? sat48_add($signed(cc_rd), ext32(ls_ff))
                                   : $signed(cc_rd);
   assign acc_new  = sat48_add(acc_rd_ff, mul_res.p);
   assign cand2    = sat48_add(cand_ff, bb_rd_ff);
   assign bidx_x   = XW'(bidx_ff);

   always_comb begin
      mul_start = 1'b0;
      mul_a     = ext32(cons_ff);
      mul_b     = ext32(mult_ff);
      div_start = 1'b0;
      cc_we     = 1'b0;
      cc_waddr  = t_ff;
      cc_wdata  = sat48_add(ext32(prod_ff), mul_res.p);
      acc_we    = 1'b0;
      acc_waddr = t_ff;
      acc_wdata = '0;
      su_we     = 1'b0;
      bb_we     = 1'b0;
      bb_waddr  = '0;
      bb_wdata  = '0;
      unique case (state_ff)
         S_MCS: begin
            mul_start = 1'b1;
            div_start = !zero_beta_ff;
         end
         S_INIT: begin
            cc_we  = 1'b1;
            acc_we = 1'b1;
            su_we  = 1'b1;
            bb_we  = (t_ff == '0);
         end
         S_LD: begin
            cc_we    = (s_ff < t_ff);
            cc_waddr = s_ff;
            cc_wdata = carry_ld;
         end
         S_MBS: begin
            mul_start = 1'b1;
            mul_a     = ext32(beta_ff);
            mul_b     = price_ff;
         end
         S_MDS: begin
            mul_start = 1'b1;
            mul_a     = diff_ff;
            mul_b     = demand_ff;
         end
         S_MDW: begin
            acc_we    = mul_res.done;
            acc_waddr = s_ff;
            acc_wdata = acc_new;
         end
         S_END: begin
            bb_we    = 1'b1;
            bb_waddr = CW'(t_ff) + CW'(1);
            bb_wdata = best_ff;
         end
         default: begin
         end
      endcase
   end

   lspdp_mulq u_mulq (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .res   (mul_res)
   );

   lspdp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({alpha_ff, 16'd0}),
      .den   ({beta_ff[31], beta_ff, 1'b0}),
      .res   (div_res)
   );

   lspdp_ram #(.WIDTH(48), .DEPTH(HORIZON)) u_carried (
      .clock (clock), .we (cc_we), .waddr (cc_waddr), .wdata (cc_wdata),
      .raddr (s_ff), .rdata_ff (cc_rd)
   );

   lspdp_ram #(.WIDTH(48), .DEPTH(HORIZON)) u_accum (
      .clock (clock), .we (acc_we), .waddr (acc_waddr), .wdata (acc_wdata),
      .raddr (s_ff), .rdata_ff (acc_rd)
   );

   lspdp_ram #(.WIDTH(32), .DEPTH(HORIZON)) u_setup (
      .clock (clock), .we (su_we), .waddr (t_ff), .wdata (setup_ff),
      .raddr (s_ff), .rdata_ff (su_rd)
   );

   lspdp_ram #(.WIDTH(48), .DEPTH(HORIZON + 1)) u_best (
      .clock (clock), .we (bb_we), .waddr (bb_waddr), .wdata (bb_wdata),
      .raddr (CW'(s_ff)), .rdata_ff (bb_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ls_ff    <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  alpha_ff     <= req_if.alpha;
                  beta_ff      <= req_if.beta;
                  prod_ff      <= req_if.production_cost;
                  stor_ff      <= req_if.storage_cost;
                  cons_ff      <= req_if.consumption;
                  mult_ff      <= req_if.multiplier;
                  setup_ff     <= req_if.setup_cost;
                  zero_beta_ff <= (req_if.beta == '0);
                  t_ff         <= AW'(cnt_eff);
                  count_ff     <= cnt_eff;
                  if (cnt_eff >= CW'(HORIZON)) begin
                     price_out_ff  <= '0;
                     start_out_ff  <= '0;
                     total_out_ff  <= '0;
                     status_out_ff <= lspdp_pkg::STATUS_HORIZON;
                     state_ff      <= S_OUT;
                  end else begin
                     state_ff <= S_MCS;
                  end
               end
            end
            S_MCS: begin
               if (zero_beta_ff) begin
                  quot_ff <= alpha_ff[31] ? lspdp_pkg::MIN48 : lspdp_pkg::MAX48;
               end
               state_ff <= S_MCW;
            end
            S_MCW: begin
               if (mul_res.done) begin
                  state_ff <= S_INIT;
               end
            end
            S_INIT: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (zero_beta_ff || div_res.done) begin
                  if (!zero_beta_ff) begin
                     quot_ff <= div_res.q;
                  end
                  s_ff     <= '0;
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               state_ff <= S_LD;
            end
            S_LD: begin
               carry_ff    <= carry_ld;
               acc_rd_ff   <= $signed(acc_rd);
               setup_rd_ff <= $signed(su_rd);
               bb_rd_ff    <= $signed(bb_rd);
               state_ff    <= S_PR;
            end
            S_PR: begin
               price_ff <= sat48_add(carry_ff >>> 1, quot_ff);
               state_ff <= S_MBS;
            end
            S_MBS: begin
               state_ff <= S_MBW;
            end
            S_MBW: begin
               if (mul_res.done) begin
                  demand_ff <= sat48_sub(ext32(alpha_ff), mul_res.p);
                  diff_ff   <= sat48_sub(carry_ff, price_ff);
                  state_ff  <= S_MDS;
               end
            end
            S_MDS: begin
               state_ff <= S_MDW;
            end
            S_MDW: begin
               if (mul_res.done) begin
                  acc_ff   <= acc_new;
                  state_ff <= S_C1;
               end
            end
            S_C1: begin
               cand_ff  <= sat48_add(acc_ff, ext32(setup_rd_ff));
               state_ff <= S_C2;
            end
            S_C2: begin
               if ((s_ff == '0) || (cand2 < best_ff)) begin
                  best_ff   <= cand2;
                  bidx_ff   <= s_ff;
                  bprice_ff <= price_ff;
               end
               if (s_ff == t_ff) begin
                  state_ff <= S_END;
               end else begin
                  s_ff     <= s_ff + AW'(1);
                  state_ff <= S_RD;
               end
            end
            S_END: begin
               count_ff      <= CW'(t_ff) + CW'(1);
               ls_ff         <= stor_ff;
               price_out_ff  <= sat32(bprice_ff);
               start_out_ff  <= bidx_x[5:0];
               total_out_ff  <= best_ff;
               status_out_ff <= zero_beta_ff ? lspdp_pkg::STATUS_ZERO_BETA
                                             : lspdp_pkg::STATUS_OK;
               state_ff      <= S_OUT;
            end
            S_OUT: begin
               if (rsp_if.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_if.ready        = (state_ff == S_IDLE);
   assign rsp_if.valid        = (state_ff == S_OUT);
   assign rsp_if.price        = price_out_ff;
   assign rsp_if.chosen_start = start_out_ff;
   assign rsp_if.best_total   = total_out_ff;
   assign rsp_if.status       = status_out_ff;

endmodule

### hdl/lspdp_checker.sv
// ----------------------------------------------------------------------------
// Lot sizing pricing checker
// Port-level assertions on the core's request and result channels.
// ----------------------------------------------------------------------------
`include "lot_sizing_pricing_dp_core_defines.svh"

module lspdp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_chosen_start,
   input logic [47:0] rsp_best_total,
   input logic [1:0]  rsp_status
);

   `LSPDP_ASSERT(a_one_item, clock, reset, rsp_valid |-> !req_ready, "item taken while result pending")
   `LSPDP_ASSERT(a_busy_after_take, clock, reset, req_valid && req_ready |=> !req_ready, "ready right after take")
   `LSPDP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_total), "stalled result changed")
   `LSPDP_ASSERT(a_horizon_zero, clock, reset, rsp_valid && (rsp_status == lspdp_pkg::STATUS_HORIZON) |-> (rsp_best_total == 48'd0) && (rsp_chosen_start == 6'd0), "horizon result not zero")
   `LSPDP_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind lot_sizing_pricing_dp_core lspdp_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_chosen_start (rsp_if.chosen_start),
   .rsp_best_total   (rsp_if.best_total),
   .rsp_status       (rsp_if.status)
);
